[hdl/bewma_pkg.sv]
`timescale 1ns / 1ps

package bewma_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_COUNT  = 255;
    localparam int MS_W       = 27;
    localparam int CNT_W      = 8;
    localparam int ALPHA_W    = 17;
    localparam int Q_W        = MS_W + FRAC_BITS;
    localparam int W_W        = FRAC_BITS + 1;
    localparam int STEP_W     = $clog2(MAX_COUNT + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 27;
    localparam int DIV_STEPS  = Q_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int MUL_B_W    = 16;
    localparam int MUL_CNT_W  = 2;

    localparam logic [MS_W-1:0] LIMIT_MS = MS_W'(24 * 60 * 60 * 1000);
    localparam logic [W_W-1:0]  ONE_Q    = W_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INIT  = 1'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POW,
        ST_POW_WAIT,
        ST_DIV,
        ST_AVG0,
        ST_AVG1,
        ST_DEV0,
        ST_DEV1,
        ST_OUT
    } t_state;

    // control from the sequencer to the multiply unit
    typedef struct packed {
        logic             start;
        logic [Q_W-1:0]   a;
        logic [W_W-1:0]   w;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [Q_W+W_W-1:0] prod;
    } t_mul_rsp;

endpackage

[hdl/bewma_mul.sv]
`timescale 1ns / 1ps

// Shared multiplier: a (Q_W bits) times w (W_W bits), 16 bits of a per cycle.
module bewma_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bewma_pkg::t_mul_req i_req,
    output bewma_pkg::t_mul_rsp o_rsp
);
    import bewma_pkg::*;

    localparam int NCHUNK = (Q_W + MUL_B_W - 1) / MUL_B_W;
    localparam int A_PAD  = NCHUNK * MUL_B_W;
    localparam int P_W    = Q_W + W_W;
    // room for a partial product placed at the top chunk before it is shifted down
    localparam int ACC_W  = A_PAD + W_W;

    logic [A_PAD-1:0]     r_a, n_a;
    logic [W_W-1:0]       r_w, n_w;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [MUL_B_W+W_W-1:0] w_part;

    assign w_part = r_a[MUL_B_W-1:0] * r_w;

    always_comb begin
        n_a    = r_a;
        n_w    = r_w;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_a    = A_PAD'(i_req.a);
            n_w    = i_req.w;
            n_acc  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // shift-and-add one 16-bit chunk per cycle, low chunk first
            n_acc = (r_acc >> MUL_B_W)
                  + (ACC_W'(w_part) << (MUL_B_W * (NCHUNK - 1)));
            n_a   = r_a >> MUL_B_W;
            n_cnt = r_cnt + MUL_CNT_W'(1);
            if (r_cnt == MUL_CNT_W'(NCHUNK - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_w   <= n_w;
        r_acc <= n_acc;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc[P_W-1:0];

endmodule

[hdl/batched_ewma_latency_tracker_top.sv]
`timescale 1ns / 1ps

// Batched EWMA latency tracker. Each word on the input channel is a batch
// (summed time in ms, sample count); each produces exactly one result word
// holding the integer running average, the integer mean absolute deviation
// and an accepted flag. Batches of 86400000 ms or more, or with a count of
// zero, leave the state alone and report accepted = 0. One shared multiplier
// (16 bits of operand per cycle; it loads the operands, works through three
// 16-bit chunks and then reports the product) computes (1-alpha)^count over
// count steps and then the four blend products; a restoring divider takes
// one quotient bit per cycle for total/count. The input is not ready while a
// batch is in work.
// Configuration writes (index 0 alpha, index 1 initial average) are taken
// only while idle; writing the initial average reloads the running average.
module batched_ewma_latency_tracker_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bewma_pkg::MS_W-1:0]  i_total_time_ms,
    input  logic [bewma_pkg::CNT_W-1:0] i_sample_count,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bewma_pkg::MS_W-1:0]  o_average_ms,
    output logic [bewma_pkg::MS_W-1:0]  o_deviation_ms,
    output logic                       o_accepted,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [bewma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bewma_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bewma_pkg::*;

    t_state r_state, n_state;

    logic [ALPHA_W-1:0] r_alpha;
    logic [Q_W-1:0]     r_avg, r_dev;
    logic [MS_W-1:0]    r_total;
    logic [CNT_W-1:0]   r_count;
    logic [STEP_W-1:0]  r_steps;
    logic [W_W-1:0]     r_p;
    logic [Q_W-1:0]     r_quo;
    logic [CNT_W:0]     r_rem;
    logic [Q_W-1:0]     r_num;
    logic [DIV_CNT_W-1:0] r_dcnt;
    logic [Q_W+W_W-1:0] r_sum;
    logic               r_acc;
    logic               r_mul_go;

    t_mul_req w_req;
    t_mul_rsp w_rsp;

    logic [W_W-1:0] w_oma, w_beta;
    logic [Q_W-1:0] w_err;
    logic [CNT_W:0] w_rem_sh;
    logic           w_ok;

    bewma_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // saturate alpha at one
    assign w_oma  = (r_alpha > ALPHA_W'(ONE_Q)) ? '0 : ONE_Q - W_W'(r_alpha);
    assign w_beta = ONE_Q - r_p;
    assign w_err  = (r_quo >= r_avg) ? r_quo - r_avg : r_avg - r_quo;
    assign w_rem_sh = {r_rem[CNT_W-1:0], r_num[Q_W-1]};
    assign w_ok   = (i_total_time_ms < LIMIT_MS) && (i_sample_count != '0);

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = w_ok ? ST_POW : ST_OUT;
            end
            ST_POW: begin
                n_state = (r_steps == '0) ? ST_DIV : ST_POW_WAIT;
            end
            ST_POW_WAIT: begin
                if (w_rsp.done) n_state = ST_POW;
            end
            ST_DIV: begin
                if (r_dcnt == '0) n_state = ST_AVG0;
            end
            ST_AVG0: begin
                if (w_rsp.done) n_state = ST_AVG1;
            end
            ST_AVG1: begin
                if (w_rsp.done) n_state = ST_DEV0;
            end
            ST_DEV0: begin
                if (w_rsp.done) n_state = ST_DEV1;
            end
            ST_DEV1: begin
                if (w_rsp.done) n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // multiplier operands: issue on entry to each product state
    always_comb begin
        w_req.start = r_mul_go;
        w_req.a     = '0;
        w_req.w     = '0;
        case (r_state)
            ST_POW_WAIT: begin
                w_req.a = Q_W'(r_p);
                w_req.w = w_oma;
            end
            ST_AVG0: begin
                w_req.a = r_avg;
                w_req.w = r_p;
            end
            ST_AVG1: begin
                w_req.a = r_quo;
                w_req.w = w_beta;
            end
            ST_DEV0: begin
                w_req.a = r_dev;
                w_req.w = r_p;
            end
            ST_DEV1: begin
                w_req.a = w_err;
                w_req.w = w_beta;
            end
            default: begin
                w_req.a = '0;
                w_req.w = '0;
            end
        endcase
    end

    assign o_valid        = (r_state == ST_OUT);
    assign o_average_ms   = r_avg[Q_W-1:FRAC_BITS];
    assign o_deviation_ms = r_dev[Q_W-1:FRAC_BITS];
    assign o_accepted     = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_alpha  <= ALPHA_W'(6554);
            r_avg    <= '0;
            r_dev    <= '0;
            r_acc    <= 1'b0;
            r_mul_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mul_go <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == REG_ALPHA)
                            r_alpha <= i_cfg_data[ALPHA_W-1:0];
                        else if (i_cfg_index == REG_INIT)
                            r_avg <= {i_cfg_data[MS_W-1:0], FRAC_BITS'(0)};
                    end
                    if (i_valid) begin
                        r_acc   <= w_ok;
                        r_total <= i_total_time_ms;
                        r_count <= i_sample_count;
                        r_steps <= (32'(i_sample_count) > MAX_COUNT)
                                 ? STEP_W'(MAX_COUNT) : STEP_W'(i_sample_count);
                        r_p     <= ONE_Q;
                    end
                end
                ST_POW: begin
                    if (r_steps != '0) begin
                        r_steps  <= r_steps - STEP_W'(1);
                        r_mul_go <= 1'b1;
                    end else begin
                        // prime the divider: numerator total<<F
                        r_num  <= {r_total, FRAC_BITS'(0)};
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_dcnt <= DIV_CNT_W'(DIV_STEPS - 1);
                    end
                end
                ST_POW_WAIT: begin
                    if (w_rsp.done) r_p <= W_W'(w_rsp.prod >> FRAC_BITS);
                end
                ST_DIV: begin
                    // one restoring quotient bit per cycle
                    if (w_rem_sh >= {1'b0, r_count}) begin
                        r_rem <= w_rem_sh - {1'b0, r_count};
                        r_quo <= {r_quo[Q_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem_sh;
                        r_quo <= {r_quo[Q_W-2:0], 1'b0};
                    end
                    r_num  <= r_num << 1;
                    r_dcnt <= r_dcnt - DIV_CNT_W'(1);
                    if (r_dcnt == '0) r_mul_go <= 1'b1;
                end
                ST_AVG0: begin
                    if (w_rsp.done) begin
                        r_sum    <= w_rsp.prod;
                        r_mul_go <= 1'b1;
                    end
                end
                ST_AVG1: begin
                    if (w_rsp.done) begin
                        r_avg    <= Q_W'((r_sum + w_rsp.prod) >> FRAC_BITS);
                        r_mul_go <= 1'b1;
                    end
                end
                ST_DEV0: begin
                    if (w_rsp.done) begin
                        r_sum    <= w_rsp.prod;
                        r_mul_go <= 1'b1;
                    end
                end
                ST_DEV1: begin
                    if (w_rsp.done)
                        r_dev <= Q_W'((r_sum + w_rsp.prod) >> FRAC_BITS);
                end
                default: begin
                    r_mul_go <= 1'b0;
                end
            endcase
        end
    end

endmodule

[tb/batched_ewma_latency_tracker_top_tb.sv]
`timescale 1ns / 1ps

module batched_ewma_latency_tracker_top_tb;
    import bewma_pkg::*;

    typedef struct packed {
        logic [MS_W-1:0]  total;
        logic [CNT_W-1:0] count;
    } t_batch;

    typedef struct packed {
        logic [MS_W-1:0] average;
        logic [MS_W-1:0] deviation;
        logic            accepted;
    } t_stats;

    localparam longint unsigned ONE      = 64'd1 << FRAC_BITS;
    localparam longint unsigned FRAC_MSK = ONE - 1;
    localparam longint unsigned DAY_MS   = 64'd86400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [MS_W-1:0] i_total_time_ms = '0;
    logic [CNT_W-1:0] i_sample_count = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [MS_W-1:0] o_average_ms;
    logic [MS_W-1:0] o_deviation_ms;
    logic o_accepted;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    batched_ewma_latency_tracker_top u_top (.*);

    // tracker state as the block should hold it
    longint unsigned alpha_reg;
    longint unsigned avg_q;
    longint unsigned dev_q;

    t_batch batch_q[$];
    t_stats stats_q[$];
    int     n_errors = 0;
    bit     no_idle = 1'b0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("batched_ewma_latency_tracker_top_tb: errors");
        $finish;
    end

    function automatic longint unsigned blend(longint unsigned a, longint unsigned wa,
                                              longint unsigned b, longint unsigned wb);
        longint unsigned hi;
        longint unsigned lo;
        hi = (a >> FRAC_BITS) * wa + (b >> FRAC_BITS) * wb;
        lo = ((a & FRAC_MSK) * wa + (b & FRAC_MSK) * wb) >> FRAC_BITS;
        return hi + lo;
    endfunction

    // advance the tracker by one batch and return the word it should report
    function automatic t_stats track_batch(t_batch b);
        t_stats          r;
        longint unsigned oma, p, beta, rt, err, a;
        int              steps;
        r.accepted = 1'b0;
        if (longint'(b.total) < DAY_MS && b.count != 0) begin
            a     = (alpha_reg > ONE) ? ONE : alpha_reg;
            oma   = ONE - a;
            steps = (b.count > MAX_COUNT) ? MAX_COUNT : b.count;
            p     = ONE;
            for (int i = 0; i < steps; i++)
                p = (p * oma) >> FRAC_BITS;
            beta  = ONE - p;
            rt    = (longint'(b.total) << FRAC_BITS) / b.count;
            avg_q = blend(avg_q, p, rt, beta);
            err   = (rt >= avg_q) ? rt - avg_q : avg_q - rt;
            dev_q = blend(dev_q, p, err, beta);
            r.accepted = 1'b1;
        end
        r.average   = MS_W'(avg_q >> FRAC_BITS);
        r.deviation = MS_W'(dev_q >> FRAC_BITS);
        return r;
    endfunction

    // driver: present the next batch after a drawn gap; predict on acceptance
    int feed_gap = 0;
    always @(posedge i_clk) begin
        t_batch b;
        bit     fire;
        fire = i_valid && o_ready;
        if (fire)
            stats_q.push_back(track_batch({i_total_time_ms, i_sample_count}));
        if (!i_valid || fire) begin
            if (feed_gap > 0) begin
                feed_gap = feed_gap - 1;
                i_valid <= 1'b0;
            end else if (i_rst_n && batch_q.size() > 0) begin
                b = batch_q.pop_front();
                i_total_time_ms <= b.total;
                i_sample_count  <= b.count;
                i_valid <= 1'b1;
                feed_gap = no_idle ? 0 : $urandom_range(0, 8);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result word with the oldest prediction, stall at random
    int drain_stall = 0;
    always @(posedge i_clk) begin
        t_stats want;
        if (o_valid && i_ready) begin
            if (stats_q.size() == 0) begin
                $error("unexpected result word: avg %0d dev %0d acc %0d",
                       o_average_ms, o_deviation_ms, o_accepted);
                n_errors++;
            end else begin
                want = stats_q.pop_front();
                if (o_average_ms !== want.average) begin
                    $error("average_ms: expected %0d, got %0d", want.average, o_average_ms);
                    n_errors++;
                end
                if (o_deviation_ms !== want.deviation) begin
                    $error("deviation_ms: expected %0d, got %0d",
                           want.deviation, o_deviation_ms);
                    n_errors++;
                end
                if (o_accepted !== want.accepted) begin
                    $error("accepted: expected %0d, got %0d", want.accepted, o_accepted);
                    n_errors++;
                end
            end
            drain_stall = no_idle ? 0 : $urandom_range(0, 8);
        end
        if (drain_stall > 0) begin
            drain_stall = drain_stall - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx == REG_ALPHA) begin
            alpha_reg = data & ((64'd1 << ALPHA_W) - 1);
        end else begin
            avg_q = longint'(data) << FRAC_BITS;
        end
        i_cfg_valid <= 1'b0;
    endtask

    // hold until every predicted word has come back, then let the block settle
    task automatic drain();
        while (batch_q.size() > 0 || i_valid || stats_q.size() > 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_batch rand_batch();
        t_batch b;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            b.total = MS_W'($urandom_range(86400000, 134217727));
            b.count = CNT_W'($urandom_range(0, 255));
        end else if (pick < 16) begin
            b.total = MS_W'($urandom_range(0, 134217727));
            b.count = '0;
        end else begin
            b.total = ($urandom_range(0, 3) == 0) ? MS_W'($urandom_range(0, 86399999))
                                                  : MS_W'($urandom_range(0, 4000));
            b.count = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(1, 255))
                                                  : CNT_W'($urandom_range(1, 12));
        end
        return b;
    endfunction

    initial begin
        alpha_reg = 6554;
        avg_q     = 0;
        dev_q     = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, both rejection cases
        batch_q.push_back({27'd0, 8'd1});
        batch_q.push_back({27'd86399999, 8'd1});
        batch_q.push_back({27'd86400000, 8'd1});
        batch_q.push_back({27'd134217727, 8'd255});
        batch_q.push_back({27'd5000, 8'd0});
        batch_q.push_back({27'd1000, 8'd255});
        batch_q.push_back({27'd86399999, 8'd255});
        batch_q.push_back({27'd0, 8'd7});
        drain();

        // alpha of one, highest legal starting average
        write_reg(REG_ALPHA, 27'd65536);
        write_reg(REG_INIT, 27'd86399999);
        batch_q.push_back({27'd12345, 8'd3});
        batch_q.push_back({27'd0, 8'd128});
        batch_q.push_back({27'd86399999, 8'd2});
        batch_q.push_back({27'd99999999, 8'd0});
        drain();

        // alpha zero: state must not move although the batch counts
        write_reg(REG_ALPHA, 27'd0);
        write_reg(REG_INIT, 27'd0);
        batch_q.push_back({27'd50000, 8'd10});
        batch_q.push_back({27'd86399999, 8'd255});
        batch_q.push_back({27'd1, 8'd1});
        drain();

        // alpha above one saturates; starting average at the top of its field
        write_reg(REG_ALPHA, 27'h1ffff);
        write_reg(REG_INIT, 27'h7ffffff);
        batch_q.push_back({27'd777, 8'd1});
        batch_q.push_back({27'd65536, 8'd200});
        batch_q.push_back({27'd300, 8'd0});
        drain();

        // random phases; high data bits on the alpha write are dropped
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_ALPHA, (ph % 3 == 0) ? CFG_DATA_W'($urandom_range(0, 134217727))
                                               : CFG_DATA_W'($urandom_range(0, 20000)));
            write_reg(REG_INIT, (ph == 9) ? 27'd0
                                          : CFG_DATA_W'($urandom_range(0, 86399999)));
            no_idle = (ph % 4 == 1);
            for (int k = 0; k < 143; k++)
                batch_q.push_back(rand_batch());
            drain();
        end
        no_idle = 1'b0;

        if (n_errors == 0) begin
            $display("batched_ewma_latency_tracker_top_tb: clean");
        end else begin
            $display("batched_ewma_latency_tracker_top_tb: errors");
        end
        $finish;
    end

endmodule
